// File: hdl/mnes_pkg.sv
// Shared types and constants for the MIDI note echo scheduler.
package mnes_pkg;

	// Command codes on the input channel.
	localparam logic CMD_EVENT = 1'b0;
	localparam logic CMD_TICK  = 1'b1;

	// Configuration register indexes.
	localparam int CFG_INDEX_W = 2;
	localparam int CFG_DATA_W  = 11;
	localparam logic [CFG_INDEX_W-1:0] CFG_ECHO_DELAY      = 2'd0;
	localparam logic [CFG_INDEX_W-1:0] CFG_PITCH_OFFSET    = 2'd1;
	localparam logic [CFG_INDEX_W-1:0] CFG_VELOCITY_OFFSET = 2'd2;
	localparam logic [CFG_INDEX_W-1:0] CFG_CHANNEL_SELECT  = 2'd3;

	// Register reset values.
	localparam logic [10:0] ECHO_DELAY_RESET = 11'd1000;

	// Length given to a key-on event.
	localparam logic [15:0] KEYON_LENGTH = 16'd100;

	// Echoes emitted per tick at most.
	localparam int MAX_RESULTS = 32;
	localparam int CNT_W       = $clog2(MAX_RESULTS + 1);

	// Classified item passed from the front end to the sequencer.
	typedef struct packed {
		logic        is_tick;
		logic [3:0]  channel;
		logic [6:0]  pitch;
		logic [6:0]  velocity;
		logic [15:0] length;
		logic [10:0] delay;
		logic [8:0]  pitch_off;
		logic [8:0]  vel_off;
	} item_t;

	// One pending echo entry as stored in the slot memory.
	typedef struct packed {
		logic [31:0] due;
		logic [3:0]  channel;
		logic [6:0]  pitch;
		logic [6:0]  velocity;
		logic [15:0] length;
	} slot_t;

	localparam int SLOT_W = $bits(slot_t);

	// One emitted echo.
	typedef struct packed {
		logic [3:0]  channel;
		logic [6:0]  pitch;
		logic [6:0]  velocity;
		logic [15:0] length;
		logic        last;
	} result_t;

endpackage

// File: hdl/mnes_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
module mnes_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 32
) (
	input  logic                                   clk,
	input  logic                                   we,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                       wdata,
	input  logic                                   re,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                       rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	// Write port.
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	// Registered read port; the data holds while no read is issued.
	always_ff @(posedge clk) begin
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

// File: hdl/mnes_front.sv
// Front end: configuration registers, input transfer and event classification.
module mnes_front (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cfg_we,
	input  logic [mnes_pkg::CFG_INDEX_W-1:0]    cfg_index,
	input  logic [mnes_pkg::CFG_DATA_W-1:0]     cfg_data,
	input  logic                                item_valid,
	output logic                                item_ready,
	input  logic                                cmd,
	input  logic                                is_note,
	input  logic [3:0]                          midi_channel,
	input  logic [6:0]                          note_pitch,
	input  logic [6:0]                          note_velocity,
	input  logic [15:0]                         note_length,
	input  logic                                q_can_push,
	output logic                                q_push,
	output mnes_pkg::item_t                     q_push_data
);

	logic [10:0] echo_delay_q;
	logic [8:0]  pitch_offset_q;
	logic [8:0]  velocity_offset_q;
	logic [4:0]  channel_select_q;
	logic        chan_miss;
	logic        keyon_silent;
	logic        keep;

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			echo_delay_q      <= mnes_pkg::ECHO_DELAY_RESET;
			pitch_offset_q    <= '0;
			velocity_offset_q <= '0;
			channel_select_q  <= '0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				mnes_pkg::CFG_ECHO_DELAY:      echo_delay_q      <= cfg_data;
				mnes_pkg::CFG_PITCH_OFFSET:    pitch_offset_q    <= cfg_data[8:0];
				mnes_pkg::CFG_VELOCITY_OFFSET: velocity_offset_q <= cfg_data[8:0];
				mnes_pkg::CFG_CHANNEL_SELECT:  channel_select_q  <= cfg_data[4:0];
				default: ;
			endcase
		end
	end

	// Filtering: a channel mismatch or a silent key-on drops an event.
	assign chan_miss    = (channel_select_q != 5'd0) &&
	                      (channel_select_q != ({1'b0, midi_channel} + 5'd1));
	assign keyon_silent = !is_note && (note_velocity == 7'd0);
	assign keep         = (cmd == mnes_pkg::CMD_TICK) || !(chan_miss || keyon_silent);

	assign item_ready = q_can_push;
	assign q_push     = item_valid && q_can_push && keep;

	// The item carries the settings in force when it was taken in.
	always_comb begin
		q_push_data.is_tick   = (cmd == mnes_pkg::CMD_TICK);
		q_push_data.channel   = midi_channel;
		q_push_data.pitch     = note_pitch;
		q_push_data.velocity  = note_velocity;
		q_push_data.length    = is_note ? note_length : mnes_pkg::KEYON_LENGTH;
		q_push_data.delay     = (echo_delay_q == 11'd0) ? 11'd1 : echo_delay_q;
		q_push_data.pitch_off = pitch_offset_q;
		q_push_data.vel_off   = velocity_offset_q;
	end

endmodule

// File: hdl/mnes_queue.sv
// Two-entry queue between the front end and the sequencer.
module mnes_queue (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            push,
	input  mnes_pkg::item_t push_data,
	output logic            can_push,
	input  logic            pop,
	output logic            pop_valid,
	output mnes_pkg::item_t pop_data
);

	mnes_pkg::item_t entry_q [2];
	logic            wr_ptr_q;
	logic            rd_ptr_q;
	logic [1:0]      count_q;

	assign can_push  = (count_q != 2'd2);
	assign pop_valid = (count_q != 2'd0);
	assign pop_data  = entry_q[rd_ptr_q];

	// Pointers and fill level.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= ~wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= ~rd_ptr_q;
			end
			if (push && !pop) begin
				count_q <= count_q + 2'd1;
			end else if (pop && !push) begin
				count_q <= count_q - 2'd1;
			end
		end
	end

	// Entry storage.
	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= push_data;
		end
	end

endmodule

// File: hdl/mnes_back.sv
// Sequencer: slot insertion, tick scan, echo update and output registers.
module mnes_back #(
	parameter int SLOTS = 32
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            pop_valid,
	input  mnes_pkg::item_t pop_data,
	output logic            pop,
	output logic            result_valid,
	input  logic            result_ready,
	output mnes_pkg::result_t result
);

	localparam int IW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
	localparam logic [IW-1:0] LAST_IDX = IW'(SLOTS - 1);

	typedef enum logic [4:0] {
		ST_IDLE   = 5'b00001,
		ST_INSERT = 5'b00010,
		ST_READ   = 5'b00100,
		ST_EVAL   = 5'b01000,
		ST_FLUSH  = 5'b10000
	} state_t;

	state_t                        state_q;
	logic [SLOTS-1:0]              valid_q;
	logic [IW-1:0]                 idx_q;
	logic [31:0]                   now_q;
	logic [mnes_pkg::CNT_W-1:0]    emit_cnt_q;
	mnes_pkg::item_t               cur_q;
	mnes_pkg::result_t             hold_q;
	logic                          hold_valid_q;
	mnes_pkg::result_t             out_q;
	logic                          out_valid_q;

	logic                          ram_we;
	logic                          ram_re;
	logic [mnes_pkg::SLOT_W-1:0]   ram_wdata;
	logic [mnes_pkg::SLOT_W-1:0]   ram_rdata;
	mnes_pkg::slot_t               rd_slot;
	mnes_pkg::slot_t               wr_slot;
	mnes_pkg::result_t             out_next;
	logic [31:0]                   due_diff;
	logic                          is_due;
	logic signed [9:0]             p_sum;
	logic signed [9:0]             v_sum;
	logic                          in_range;
	logic                          out_free;
	logic                          can_emit;
	logic                          emit;
	logic                          at_last;
	logic                          limit_hit;
	logic                          load_out;
	logic                          flush_go;

	mnes_ram #(
		.WIDTH (mnes_pkg::SLOT_W),
		.DEPTH (SLOTS)
	) u_slot_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (idx_q),
		.wdata (ram_wdata),
		.re    (ram_re),
		.raddr (idx_q),
		.rdata (ram_rdata)
	);

	assign rd_slot = mnes_pkg::slot_t'(ram_rdata);

	// Due test and offset arithmetic on the slot just read.
	assign due_diff = now_q - rd_slot.due;
	assign is_due   = !due_diff[31];
	assign p_sum    = $signed({3'b000, rd_slot.pitch}) +
	                  $signed({cur_q.pitch_off[8], cur_q.pitch_off});
	assign v_sum    = $signed({3'b000, rd_slot.velocity}) +
	                  $signed({cur_q.vel_off[8], cur_q.vel_off});
	assign in_range = (p_sum[9:7] == 3'b000) && (v_sum[9:7] == 3'b000) &&
	                  (v_sum[6:0] != 7'd0);

	// Output handshake: an echo can be taken when the hold stage has room.
	assign out_free  = !out_valid_q || result_ready;
	assign can_emit  = !hold_valid_q || out_free;
	assign emit      = (state_q == ST_EVAL) && is_due && in_range && can_emit;
	assign at_last   = (idx_q == LAST_IDX);
	assign limit_hit = (emit_cnt_q == mnes_pkg::CNT_W'(mnes_pkg::MAX_RESULTS));
	assign flush_go  = (state_q == ST_FLUSH) && (!hold_valid_q || out_free);
	assign load_out  = (emit && hold_valid_q) ||
	                   ((state_q == ST_FLUSH) && hold_valid_q && out_free);
	assign pop       = (state_q == ST_IDLE) && pop_valid;

	// Slot memory access for insertion and echo update.
	always_comb begin
		ram_we  = 1'b0;
		ram_re  = 1'b0;
		wr_slot = rd_slot;
		unique case (state_q)
			ST_INSERT: begin
				ram_we           = !valid_q[idx_q];
				wr_slot.due      = now_q + 32'(cur_q.delay);
				wr_slot.channel  = cur_q.channel;
				wr_slot.pitch    = cur_q.pitch;
				wr_slot.velocity = cur_q.velocity;
				wr_slot.length   = cur_q.length;
			end
			ST_READ: begin
				ram_re = !limit_hit && valid_q[idx_q];
			end
			ST_EVAL: begin
				ram_we           = emit;
				wr_slot.due      = rd_slot.due + 32'(cur_q.delay);
				wr_slot.pitch    = p_sum[6:0];
				wr_slot.velocity = v_sum[6:0];
			end
			ST_IDLE, ST_FLUSH: ;
			default: ;
		endcase
		ram_wdata = wr_slot;
	end

	// The echo moving to the output is final only when it leaves during the flush.
	always_comb begin
		out_next      = hold_q;
		out_next.last = (state_q == ST_FLUSH);
	end

	// Control state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			valid_q      <= '0;
			idx_q        <= '0;
			now_q        <= '0;
			emit_cnt_q   <= '0;
			hold_valid_q <= 1'b0;
			out_valid_q  <= 1'b0;
		end else begin
			// Output register: loaded from the hold stage, else drained.
			if (load_out) begin
				out_valid_q <= 1'b1;
			end else if (result_ready) begin
				out_valid_q <= 1'b0;
			end

			unique case (state_q)
				ST_IDLE: begin
					if (pop_valid) begin
						idx_q      <= '0;
						emit_cnt_q <= '0;
						if (pop_data.is_tick) begin
							now_q   <= now_q + 32'd1;
							state_q <= ST_READ;
						end else begin
							state_q <= ST_INSERT;
						end
					end
				end
				// Search for the lowest free slot, one slot a cycle.
				ST_INSERT: begin
					if (!valid_q[idx_q]) begin
						valid_q[idx_q] <= 1'b1;
						state_q        <= ST_IDLE;
					end else if (at_last) begin
						state_q <= ST_IDLE;
					end else begin
						idx_q <= idx_q + IW'(1);
					end
				end
				// Skip free slots; read occupied ones.
				ST_READ: begin
					if (limit_hit) begin
						state_q <= ST_FLUSH;
					end else if (valid_q[idx_q]) begin
						state_q <= ST_EVAL;
					end else if (at_last) begin
						state_q <= ST_FLUSH;
					end else begin
						idx_q <= idx_q + IW'(1);
					end
				end
				// Emit, retire or pass over the slot just read.
				ST_EVAL: begin
					if (!is_due || !in_range || can_emit) begin
						if (is_due && !in_range) begin
							valid_q[idx_q] <= 1'b0;
						end
						if (emit) begin
							hold_valid_q <= 1'b1;
							emit_cnt_q   <= emit_cnt_q + mnes_pkg::CNT_W'(1);
						end
						if (at_last) begin
							state_q <= ST_FLUSH;
						end else begin
							idx_q   <= idx_q + IW'(1);
							state_q <= ST_READ;
						end
					end
				end
				// Release the final echo of this tick with its last flag.
				ST_FLUSH: begin
					if (flush_go) begin
						hold_valid_q <= 1'b0;
						state_q      <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// Payload registers.
	always_ff @(posedge clk) begin
		if (pop) begin
			cur_q <= pop_data;
		end
		if (emit) begin
			hold_q.channel  <= rd_slot.channel;
			hold_q.pitch    <= p_sum[6:0];
			hold_q.velocity <= v_sum[6:0];
			hold_q.length   <= rd_slot.length;
			hold_q.last     <= 1'b0;
		end
		if (load_out) begin
			out_q <= out_next;
		end
	end

	assign result_valid = out_valid_q;
	assign result       = out_q;

endmodule

// File: hdl/midi_note_echo_scheduler_top.sv
// Top level of the MIDI note echo scheduler.
// An event is taken in and queued; inserting it searches the slot table at one slot
// a cycle in the sequencer.
// A tick passes over free slots and gives each occupied slot a registered slot memory read,
// then an update; each echo moves to the output when the next echo is emitted or at the scan end.
// Reset is asynchronous and active low: registers return to their reset values, all slots
// become free, time is zero and the queue and output are empty.
module midi_note_echo_scheduler_top #(
	parameter int PENDING_SLOTS = 32
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             cfg_we,
	input  logic [mnes_pkg::CFG_INDEX_W-1:0] cfg_index,
	input  logic [mnes_pkg::CFG_DATA_W-1:0]  cfg_data,
	input  logic                             item_valid,
	output logic                             item_ready,
	input  logic                             cmd,
	input  logic                             is_note,
	input  logic [3:0]                       midi_channel,
	input  logic [6:0]                       note_pitch,
	input  logic [6:0]                       note_velocity,
	input  logic [15:0]                      note_length,
	output logic                             result_valid,
	input  logic                             result_ready,
	output logic [3:0]                       out_channel,
	output logic [6:0]                       out_pitch,
	output logic [6:0]                       out_velocity,
	output logic [15:0]                      out_length,
	output logic                             last
);

	logic              q_can_push;
	logic              q_push;
	mnes_pkg::item_t   q_push_data;
	logic              q_pop;
	logic              q_pop_valid;
	mnes_pkg::item_t   q_pop_data;
	mnes_pkg::result_t result;

	// Front end: configuration and classification.
	mnes_front u_front (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_we        (cfg_we),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data),
		.item_valid    (item_valid),
		.item_ready    (item_ready),
		.cmd           (cmd),
		.is_note       (is_note),
		.midi_channel  (midi_channel),
		.note_pitch    (note_pitch),
		.note_velocity (note_velocity),
		.note_length   (note_length),
		.q_can_push    (q_can_push),
		.q_push        (q_push),
		.q_push_data   (q_push_data)
	);

	// Queue decoupling the front end from the sequencer.
	mnes_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (q_push),
		.push_data (q_push_data),
		.can_push  (q_can_push),
		.pop       (q_pop),
		.pop_valid (q_pop_valid),
		.pop_data  (q_pop_data)
	);

	// Sequencer with the slot table.
	mnes_back #(
		.SLOTS (PENDING_SLOTS)
	) u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.pop_valid    (q_pop_valid),
		.pop_data     (q_pop_data),
		.pop          (q_pop),
		.result_valid (result_valid),
		.result_ready (result_ready),
		.result       (result)
	);

	assign out_channel  = result.channel;
	assign out_pitch    = result.pitch;
	assign out_velocity = result.velocity;
	assign out_length   = result.length;
	assign last         = result.last;

endmodule

// File: test/midi_note_echo_scheduler_tb.sv
// Self-checking testbench for the MIDI note echo scheduler with an echo predictor.
`timescale 1ns / 100ps

module tb;

	localparam int PENDING_SLOTS = 32;
	// A tick scans every slot and an event insert searches up to every slot; the drain wait
	// allows for either behind the last echo, for each item still in the input queue.
	localparam int DRAIN_CYCLES = 1000;
	localparam int LONG_HOLD = 500;
	// The limit is several times the slowest correct run: some 200 items at worst a full scan
	// and 32 stalled echoes each, plus the settling waits.
	localparam int LIMIT = 600_000;

	// One item as offered on the input channel, with a flag that makes the sender wait first.
	typedef struct packed {
		logic        hold_for_drain;
		logic        cmd;
		logic        is_note;
		logic [3:0]  channel;
		logic [6:0]  pitch;
		logic [6:0]  velocity;
		logic [15:0] length;
	} midi_item_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_we = 1'b0;
	logic [mnes_pkg::CFG_INDEX_W-1:0] cfg_index = '0;
	logic [mnes_pkg::CFG_DATA_W-1:0] cfg_data = '0;
	logic item_valid = 1'b0;
	logic result_ready = 1'b0;
	midi_item_t offered = '0;

	wire item_ready;
	wire result_valid;
	wire [3:0] out_channel;
	wire [6:0] out_pitch;
	wire [6:0] out_velocity;
	wire [15:0] out_length;
	wire last;

	wire cmd = offered.cmd;
	wire is_note = offered.is_note;
	wire [3:0] midi_channel = offered.channel;
	wire [6:0] note_pitch = offered.pitch;
	wire [6:0] note_velocity = offered.velocity;
	wire [15:0] note_length = offered.length;

	// Echo timing and note state held by the predictor.
	logic [10:0] echo_period;
	logic signed [8:0] pitch_shift;
	logic signed [8:0] vel_shift;
	logic [4:0] chan_filter;
	logic [31:0] clock_ms;
	bit slot_busy [PENDING_SLOTS];
	mnes_pkg::slot_t slots [PENDING_SLOTS];

	midi_item_t pending_items[$];
	mnes_pkg::result_t echoes_due[$];

	bit item_fire = 1'b0;
	bit result_fire = 1'b0;
	bit pace_gaps = 1'b0;
	int send_gap = 0;
	int stall_left = 0;
	int hold_left = 0;
	int holds_asked = 0;
	int holds_served = 0;
	int failures = 0;
	int items_taken = 0;
	int echoes_checked = 0;
	int writes_done = 0;
	int cycle_count = 0;

	midi_note_echo_scheduler_top #(
		.PENDING_SLOTS(PENDING_SLOTS)
	) u_top (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.item_valid(item_valid),
		.item_ready(item_ready),
		.cmd(cmd),
		.is_note(is_note),
		.midi_channel(midi_channel),
		.note_pitch(note_pitch),
		.note_velocity(note_velocity),
		.note_length(note_length),
		.result_valid(result_valid),
		.result_ready(result_ready),
		.out_channel(out_channel),
		.out_pitch(out_pitch),
		.out_velocity(out_velocity),
		.out_length(out_length),
		.last(last)
	);

	always #1 clk = ~clk;

	// A delay of zero behaves as one tick.
	function automatic logic [31:0] echo_step();
		return (echo_period == 11'd0) ? 32'd1 : {21'd0, echo_period};
	endfunction

	function automatic int draw_wait();
		return pace_gaps ? int'($urandom_range(0, 12)) : 0;
	endfunction

	// Works out the echoes that one accepted item causes and updates the slot table.
	task automatic predict_echoes(input midi_item_t it);
		logic [15:0] len;
		int p;
		int v;
		int n;
		bit placed;
		bit have_held;
		mnes_pkg::result_t held;
		if (it.cmd == mnes_pkg::CMD_EVENT) begin
			// Filtered events and silent key-on events never reach the table.
			if ((chan_filter == 5'd0 || chan_filter == {1'b0, it.channel} + 5'd1) &&
			    (it.is_note || it.velocity != 7'd0)) begin
				len = it.is_note ? it.length : mnes_pkg::KEYON_LENGTH;
				placed = 1'b0;
				for (int i = 0; i < PENDING_SLOTS; i++) begin
					if (!placed && !slot_busy[i]) begin
						placed = 1'b1;
						slot_busy[i] = 1'b1;
						slots[i] = '{clock_ms + echo_step(), it.channel, it.pitch, it.velocity,
							len};
					end
				end
			end
		end else begin
			clock_ms = clock_ms + 32'd1;
			n = 0;
			have_held = 1'b0;
			held = '0;
			for (int i = 0; i < PENDING_SLOTS; i++) begin
				if (n < mnes_pkg::MAX_RESULTS && slot_busy[i] &&
				    (clock_ms - slots[i].due) < 32'h8000_0000) begin
					p = int'(slots[i].pitch) + int'(pitch_shift);
					v = int'(slots[i].velocity) + int'(vel_shift);
					if (v > 0 && v < 128 && p >= 0 && p < 128) begin
						slots[i] = '{slots[i].due + echo_step(), slots[i].channel, p[6:0],
							v[6:0], slots[i].length};
						// Hold each echo back one step so the final one can be marked.
						if (have_held) begin
							echoes_due.push_back(held);
						end
						held = '{slots[i].channel, p[6:0], v[6:0], slots[i].length, 1'b0};
						have_held = 1'b1;
						n++;
					end else begin
						slot_busy[i] = 1'b0;
					end
				end
			end
			if (have_held) begin
				held.last = 1'b1;
				echoes_due.push_back(held);
			end
		end
	endtask

	task automatic compare_field(input string fname, input int want, input int got);
		if (want != got) begin
			$error("%s mismatch: expected %0d, got %0d", fname, want, got);
			failures++;
		end
	endtask

	// Sample both handshakes and check each echo transfer against the oldest prediction.
	always @(posedge clk) begin : check_echoes
		mnes_pkg::result_t want;
		item_fire = arst_n && item_valid && item_ready;
		result_fire = arst_n && result_valid && result_ready;
		if (result_fire) begin
			if (echoes_due.size() == 0) begin
				$error("echo transfer with nothing expected: channel %0d pitch %0d",
					out_channel, out_pitch);
				failures++;
			end else begin
				want = echoes_due.pop_front();
				compare_field("out_channel", int'(want.channel), int'(out_channel));
				compare_field("out_pitch", int'(want.pitch), int'(out_pitch));
				compare_field("out_velocity", int'(want.velocity), int'(out_velocity));
				compare_field("out_length", int'(want.length), int'(out_length));
				compare_field("last", int'(want.last), int'(last));
			end
			echoes_checked++;
		end
	end

	// Item sender: predicts on each transfer, then waits its drawn gap before the next item.
	always @(negedge clk) begin : offer_items
		if (item_fire) begin
			predict_echoes(offered);
			items_taken++;
			send_gap = draw_wait();
		end
		if (!item_valid || item_fire) begin
			if (send_gap > 0) begin
				send_gap--;
				item_valid <= 1'b0;
			end else if (pending_items.size() != 0 &&
			    !(pending_items[0].hold_for_drain && echoes_due.size() != 0)) begin
				offered <= pending_items.pop_front();
				item_valid <= 1'b1;
			end else begin
				item_valid <= 1'b0;
			end
		end
	end

	// Echo receiver: a stall drawn after each transfer, and long holds on request.
	always @(negedge clk) begin : pace_echoes
		if (holds_served < holds_asked) begin
			hold_left = LONG_HOLD;
			holds_served++;
		end
		if (hold_left > 0) begin
			hold_left--;
			result_ready <= 1'b0;
		end else begin
			if (result_fire) begin
				stall_left = draw_wait();
			end
			if (stall_left > 0) begin
				stall_left--;
				result_ready <= 1'b0;
			end else begin
				result_ready <= 1'b1;
			end
		end
	end

	initial begin : watchdog
		while (cycle_count < LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("Timed out after %0d cycles with %0d echoes outstanding.", cycle_count,
			echoes_due.size());
		$display("CHECK FAILED");
		$finish;
	end

	function automatic midi_item_t random_item();
		midi_item_t it;
		it.hold_for_drain = 1'b0;
		it.cmd = mnes_pkg::CMD_EVENT;
		it.is_note = 1'($urandom_range(0, 1));
		it.channel = 4'($urandom_range(0, 15));
		it.pitch = 7'($urandom_range(0, 127));
		it.velocity = 7'($urandom_range(0, 127));
		it.length = 16'($urandom_range(0, 65535));
		return it;
	endfunction

	function automatic void queue_event(input bit note, input int ch, input int p, input int v,
	    input int len);
		midi_item_t it;
		it = random_item();
		it.is_note = note;
		it.channel = ch[3:0];
		it.pitch = p[6:0];
		it.velocity = v[6:0];
		it.length = len[15:0];
		pending_items.push_back(it);
	endfunction

	function automatic void queue_ticks(input int count);
		midi_item_t it;
		for (int i = 0; i < count; i++) begin
			it = random_item();
			it.cmd = mnes_pkg::CMD_TICK;
			pending_items.push_back(it);
		end
	endfunction

	// Wait until every item is taken, every echo has arrived and the block has gone quiet.
	task automatic settle();
		while (pending_items.size() != 0 || item_valid || echoes_due.size() != 0) begin
			@(posedge clk);
		end
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(input logic [mnes_pkg::CFG_INDEX_W-1:0] idx,
	    input logic [mnes_pkg::CFG_DATA_W-1:0] data);
		@(negedge clk);
		cfg_we = 1'b1;
		cfg_index = idx;
		cfg_data = data;
		@(negedge clk);
		cfg_we = 1'b0;
		writes_done++;
	endtask

	task automatic apply_settings(input int dly, input int poff, input int voff, input int csel);
		settle();
		write_reg(mnes_pkg::CFG_ECHO_DELAY, 11'(dly));
		write_reg(mnes_pkg::CFG_PITCH_OFFSET, {2'b00, poff[8:0]});
		write_reg(mnes_pkg::CFG_VELOCITY_OFFSET, {2'b00, voff[8:0]});
		write_reg(mnes_pkg::CFG_CHANNEL_SELECT, {6'd0, csel[4:0]});
		echo_period = 11'(dly);
		pitch_shift = poff[8:0];
		vel_shift = voff[8:0];
		chan_filter = csel[4:0];
	endtask

	// One phase of random settings and a random mix of events and ticks.
	task automatic run_random_phase(input int count);
		midi_item_t it;
		int dly;
		int poff;
		int voff;
		int csel;
		dly = ($urandom_range(0, 4) == 0) ? int'($urandom_range(8, 40)) :
			int'($urandom_range(0, 6));
		poff = int'($urandom_range(0, 16)) - 8;
		voff = int'($urandom_range(0, 16)) - 10;
		if ($urandom_range(0, 5) == 0) begin
			poff = int'($urandom_range(0, 255)) - 127;
		end
		csel = ($urandom_range(0, 1) == 0) ? 0 : int'($urandom_range(1, 17));
		apply_settings(dly, poff, voff, csel);
		pace_gaps = ($urandom_range(0, 3) != 0);
		for (int i = 0; i < count; i++) begin
			it = random_item();
			if ($urandom_range(0, 99) < 35) begin
				it.cmd = mnes_pkg::CMD_TICK;
			end else if (csel >= 1 && csel <= 16 && $urandom_range(0, 1) == 1) begin
				it.channel = 4'(csel - 1);
			end
			if ($urandom_range(0, 7) == 0) begin
				it.velocity = 7'd0;
			end
			it.hold_for_drain = ($urandom_range(0, 19) == 0);
			pending_items.push_back(it);
		end
	endtask

	initial begin : stimulus
		midi_item_t it;
		echo_period = mnes_pkg::ECHO_DELAY_RESET;
		pitch_shift = '0;
		vel_shift = '0;
		chan_filter = '0;
		clock_ms = '0;
		for (int i = 0; i < PENDING_SLOTS; i++) begin
			slot_busy[i] = 1'b0;
		end
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Reset settings: a silent key-on is dropped, and three entries are stored that fall
		// due long after this run ends.
		queue_event(1'b0, 0, 64, 0, 0);
		queue_event(1'b1, 2, 30, 0, 300);
		queue_event(1'b0, 7, 90, 100, 0);
		queue_event(1'b1, 15, 127, 1, 65535);
		queue_ticks(2);

		// Short delay: fill the table past full, then let the new entries echo on one tick.
		apply_settings(4, 0, 0, 0);
		for (int i = 0; i < PENDING_SLOTS - 2; i++) begin
			it = random_item();
			it.is_note = i[0];
			it.channel = i[3:0];
			it.velocity = 7'($urandom_range(1, 127));
			case (i)
				0: it.pitch = 7'd0;
				1: it.pitch = 7'd127;
				2: it.velocity = 7'd127;
				3: it.length = 16'h0000;
				4: it.length = 16'hFFFF;
				default: ;
			endcase
			pending_items.push_back(it);
		end
		queue_ticks(4);

		// Offsets at their extremes retire every due entry; the filter drops every event.
		apply_settings(2000, 128, -127, 31);
		queue_event(1'b1, 3, 40, 40, 500);
		queue_event(1'b0, 15, 40, 40, 0);
		queue_ticks(6);

		// Zero delay, and entries that leave range on their first echo.
		apply_settings(0, 1, -1, 0);
		pace_gaps = 1'b1;
		queue_event(1'b0, 0, 64, 0, 0);
		queue_event(1'b1, 15, 127, 127, 65535);
		queue_event(1'b1, 0, 0, 0, 0);
		queue_event(1'b0, 3, 0, 1, 777);
		queue_event(1'b0, 5, 60, 64, 1234);
		queue_event(1'b1, 9, 10, 126, 0);
		queue_ticks(4);

		// Single-channel filter, and echoes landing on the range limits.
		apply_settings(1, -127, 127, 16);
		queue_event(1'b1, 15, 127, 0, 16'hABCD);
		queue_event(1'b0, 14, 50, 50, 0);
		queue_event(1'b0, 15, 126, 1, 0);
		queue_ticks(3);

		// Back-pressure: the receiver holds off while ticks keep coming, then one tick waits
		// for every outstanding echo.
		apply_settings(1, 2, -3, 0);
		pace_gaps = 1'b0;
		for (int i = 0; i < 8; i++) begin
			it = random_item();
			it.velocity = 7'($urandom_range(20, 127));
			pending_items.push_back(it);
		end
		queue_ticks(24);
		holds_asked++;
		it = random_item();
		it.cmd = mnes_pkg::CMD_TICK;
		it.hold_for_drain = 1'b1;
		pending_items.push_back(it);
		queue_ticks(4);

		for (int ph = 0; ph < 3; ph++) begin
			run_random_phase(30);
		end

		// Longest delay: entries are stored but none of them falls due in this run.
		apply_settings(2047, 0, 128, 0);
		pace_gaps = 1'b1;
		for (int i = 0; i < 5; i++) begin
			pending_items.push_back(random_item());
		end
		queue_ticks(5);

		settle();
		$display("Covered %0d items and %0d echo transfers over %0d register writes.",
			items_taken, echoes_checked, writes_done);
		$display("Included a full table, a held-off receiver and every filter mode.");
		if (failures == 0) begin
			$display("CHECK OK");
		end else begin
			$display("CHECK FAILED");
		end
		$finish;
	end

endmodule

// File: files.f
hdl/mnes_pkg.sv
hdl/mnes_ram.sv
hdl/mnes_front.sv
hdl/mnes_queue.sv
hdl/mnes_back.sv
hdl/midi_note_echo_scheduler_top.sv
test/midi_note_echo_scheduler_tb.sv
